// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the 3x3 mean filter.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BMF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmf assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define BMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmf assertion failed");
`else
`define BMF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/bmf_pkg.sv =====
// Constants, types and the reciprocal table of the 3x3 mean filter.
// No dependencies; used by the interfaces, the divider and the top level.
package bmf_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int COLCNT_W   = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // sum of three samples, sum of nine samples, magnitude of a nine-sample sum
  localparam int ROWSUM_W  = SAMPLE_BITS + 2;
  localparam int SUM_W     = SAMPLE_BITS + 4;
  localparam int ABS_W     = SAMPLE_BITS + 3;
  localparam int DIV_SHIFT = SAMPLE_BITS + 4;
  localparam int CNT_W     = 4;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // floor(2^DIV_SHIFT / d) for every neighbour count that can occur; 2^DIV_SHIFT - 1 for d = 1
  localparam logic [63:0] DIV_ONE = 64'd1 << DIV_SHIFT;
  localparam logic [DIV_SHIFT-1:0] RECIP_1 = DIV_SHIFT'(DIV_ONE - 64'd1);
  localparam logic [DIV_SHIFT-1:0] RECIP_2 = DIV_SHIFT'(DIV_ONE / 2);
  localparam logic [DIV_SHIFT-1:0] RECIP_3 = DIV_SHIFT'(DIV_ONE / 3);
  localparam logic [DIV_SHIFT-1:0] RECIP_4 = DIV_SHIFT'(DIV_ONE / 4);
  localparam logic [DIV_SHIFT-1:0] RECIP_6 = DIV_SHIFT'(DIV_ONE / 6);
  localparam logic [DIV_SHIFT-1:0] RECIP_9 = DIV_SHIFT'(DIV_ONE / 9);

  function automatic logic [DIV_SHIFT-1:0] recip(input logic [CNT_W-1:0] d);
    logic [DIV_SHIFT-1:0] r;
    unique case (d)
      4'd1:    r = RECIP_1;
      4'd2:    r = RECIP_2;
      4'd3:    r = RECIP_3;
      4'd4:    r = RECIP_4;
      4'd6:    r = RECIP_6;
      4'd9:    r = RECIP_9;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } div_req_t;

  typedef struct packed {
    logic    done;
    sample_t quotient;
  } div_rsp_t;

endpackage

// ===== hdl/bmf_if.sv =====
// Valid/ready channel interfaces for the samples in and the filtered items out.
// Depends on bmf_pkg.
interface bmf_in_if;
  logic              valid;
  logic              ready;
  bmf_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bmf_out_if;
  logic                        valid;
  logic                        ready;
  logic [bmf_pkg::ROW_W-1:0]   out_row;
  logic [bmf_pkg::COL_W-1:0]   out_column;
  bmf_pkg::sample_t            mean_value;
  logic                        last_of_run;

  modport source (output valid, output out_row, output out_column, output mean_value,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_row, input out_column, input mean_value,
                  input last_of_run, output ready);
endinterface

// ===== hdl/box_mean_filter_3x3.sv =====
// 3x3 box mean filter over a matrix of signed samples streamed in raster order. Each item
// in yields zero to four filtered items out, each tagged with its row and column; items of
// the last row come out of raster order. Neighbours outside the matrix are left out of
// both sum and divisor, and the mean truncates toward zero. The two earlier rows sit in one
// line memory (one word per column, read-modify-write per item). A new item is taken
// only in idle; one that yields nothing goes back to idle after S_READ, else its results
// go one by one through row sum, total, two-stage reciprocal divide and output load.
// Any register write restarts the matrix at row 0, column 0. There is no clearing pass:
// line memory words not yet written in the current matrix are masked out by position.
// Depends on bmf_pkg, bmf_if, bmf_mean_div and assert_macros.svh.
`include "assert_macros.svh"

module box_mean_filter_3x3 (
  input  logic                              clk,
  input  logic                              rst_n,
  bmf_in_if.sink                            in_chan,
  bmf_out_if.source                         out_chan,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bmf_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [bmf_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int SB    = bmf_pkg::SAMPLE_BITS;
  localparam int COL_W = bmf_pkg::COL_W;
  localparam int ROW_W = bmf_pkg::ROW_W;
  localparam int CC_W  = bmf_pkg::COLCNT_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_ROWS = 6'b000100,
    S_SUM  = 6'b001000,
    S_DIV  = 6'b010000,
    S_PUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [ROW_W-1:0] row_count_r;
  logic [CC_W-1:0]  col_count_r;
  logic             cfg_wr;
  logic [ROW_W:0]   rows_eff;
  logic [CC_W-1:0]  cols_eff;

  // position of the next sample
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;

  // item under work
  bmf_pkg::sample_t sample_r;
  logic [ROW_W-1:0] r_item_r;
  logic [COL_W-1:0] c_item_r;
  logic             last_col;
  logic             last_row;
  logic [3:0]       pend_r, pend_nxt;

  // line memory: [2*SB-1:SB] row r-1, [SB-1:0] row r-2
  logic [2*SB-1:0]  line_mem [bmf_pkg::MAX_COLUMNS];
  logic [2*SB-1:0]  rd_data_r;

  bmf_pkg::sample_t win_r [3][3];

  // result selection and sums
  logic [1:0]                              kind;
  logic [3:0]                              kind_bit;
  logic [2:0]                              cm;
  logic [2:0]                              rm;
  logic [1:0]                              ncols;
  logic [1:0]                              nrows;
  logic signed [bmf_pkg::ROWSUM_W-1:0]     rowsum_nxt [3];
  logic signed [bmf_pkg::ROWSUM_W-1:0]     rowsum_r [3];
  logic signed [bmf_pkg::SUM_W-1:0]        total;

  bmf_pkg::div_req_t div_req;
  bmf_pkg::div_rsp_t div_rsp;

  // output register
  logic             out_valid_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  bmf_pkg::sample_t out_mean_r;
  logic             out_last_r;
  logic             out_load;
  logic             in_fire;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_W'(8);
      col_count_r <= CC_W'(8);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        bmf_pkg::REG_ROW_COUNT:    row_count_r <= cfg_pwdata[ROW_W-1:0];
        bmf_pkg::REG_COLUMN_COUNT: col_count_r <= cfg_pwdata[CC_W-1:0];
        default:                   row_count_r <= row_count_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      bmf_pkg::REG_ROW_COUNT:    cfg_prdata = bmf_pkg::CFG_DATA_W'(row_count_r);
      bmf_pkg::REG_COLUMN_COUNT: cfg_prdata = bmf_pkg::CFG_DATA_W'(col_count_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // zero counts act as one; oversized column count saturates
  assign rows_eff = (row_count_r == '0) ? (ROW_W+1)'(1) : {1'b0, row_count_r};

  always_comb begin
    priority if (col_count_r == '0) begin
      cols_eff = CC_W'(1);
    end else if (col_count_r > CC_W'(bmf_pkg::MAX_COLUMNS)) begin
      cols_eff = CC_W'(bmf_pkg::MAX_COLUMNS);
    end else begin
      cols_eff = col_count_r;
    end
  end

  // ---------------- input side ----------------
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_chan.sample;
      r_item_r <= row_cnt_r;
      c_item_r <= col_cnt_r;
    end
  end

  // Read at accept, write back in S_READ; the next read comes no earlier than the next
  // accept, so the same word is never in flight twice.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= line_mem[col_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      line_mem[c_item_r] <= {sample_r, rd_data_r[2*SB-1:SB]};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= rd_data_r[SB-1:0];
      win_r[1][2] <= rd_data_r[2*SB-1:SB];
      win_r[2][2] <= sample_r;
    end
  end

  assign last_col = (({1'b0, c_item_r} + 1'b1) == cols_eff);
  assign last_row = (({1'b0, r_item_r} + 1'b1) == rows_eff);

  always_comb begin
    pend_nxt[0] = (r_item_r != '0) && (c_item_r != '0);
    pend_nxt[1] = (r_item_r != '0) && last_col;
    pend_nxt[2] = last_row && (c_item_r != '0);
    pend_nxt[3] = last_row && last_col;
  end

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (cfg_wr) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (state_r == S_READ) begin
      col_cnt_nxt = last_col ? '0 : c_item_r + 1'b1;
      if (last_col) begin
        row_cnt_nxt = last_row ? '0 : r_item_r + 1'b1;
      end
    end
  end

  // ---------------- result sequencing ----------------
  // lowest pending result first: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
  always_comb begin
    priority casez (pend_r)
      4'b???1: kind = 2'd0;
      4'b??10: kind = 2'd1;
      4'b?100: kind = 2'd2;
      default: kind = 2'd3;
    endcase
  end

  assign kind_bit = 4'b0001 << kind;

  // kind[1] drops the top window row, kind[0] the left window column
  assign cm = {1'b1, (c_item_r != '0), (!kind[0] && (c_item_r > COL_W'(1)))};
  assign rm = {1'b1, (r_item_r != '0), (!kind[1] && (r_item_r > ROW_W'(1)))};
  assign ncols = {1'b0, cm[0]} + {1'b0, cm[1]} + 2'd1;
  assign nrows = {1'b0, rm[0]} + {1'b0, rm[1]} + 2'd1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rowsum_nxt[i] = '0;
      for (int j = 0; j < 3; j++) begin
        if (cm[j]) begin
          rowsum_nxt[i] = rowsum_nxt[i] + bmf_pkg::ROWSUM_W'(win_r[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ROWS) begin
      for (int i = 0; i < 3; i++) begin
        rowsum_r[i] <= rowsum_nxt[i];
      end
    end
  end

  always_comb begin
    total = bmf_pkg::SUM_W'(rowsum_r[2]);
    if (rm[1]) total = total + bmf_pkg::SUM_W'(rowsum_r[1]);
    if (rm[0]) total = total + bmf_pkg::SUM_W'(rowsum_r[0]);
  end

  assign div_req.start = (state_r == S_SUM);
  assign div_req.sum   = total;
  assign div_req.count = bmf_pkg::CNT_W'({2'b00, nrows} * {2'b00, ncols});

  bmf_mean_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_load = (state_r == S_PUT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_READ;
      S_READ: state_nxt = (pend_nxt != '0) ? S_ROWS : S_IDLE;
      S_ROWS: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DIV;
      S_DIV:  if (div_rsp.done) state_nxt = S_PUT;
      S_PUT: begin
        if (out_load) begin
          state_nxt = ((pend_r & ~kind_bit) != '0) ? S_ROWS : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pend_r    <= '0;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
      if (state_r == S_READ) begin
        pend_r <= pend_nxt;
      end else if (out_load) begin
        pend_r <= pend_r & ~kind_bit;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= kind[1] ? r_item_r : r_item_r - 1'b1;
      out_col_r  <= kind[0] ? c_item_r : c_item_r - 1'b1;
      out_mean_r <= div_rsp.quotient;
      out_last_r <= ((pend_r & ~kind_bit) == '0);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_row     = out_row_r;
  assign out_chan.out_column  = out_col_r;
  assign out_chan.mean_value  = out_mean_r;
  assign out_chan.last_of_run = out_last_r;

  // ---------------- assertions ----------------
  `BMF_ASSERT_NEXT(a_read_follows_accept, clk, rst_n, in_fire, state_r == S_READ)
  `BMF_ASSERT_IMPL(a_work_has_pending, clk, rst_n, (state_r == S_ROWS) || (state_r == S_SUM) || (state_r == S_DIV) || (state_r == S_PUT), pend_r != '0)
  `BMF_ASSERT_IMPL(a_div_done_while_waiting, clk, rst_n, div_rsp.done, state_r == S_DIV)
  `BMF_ASSERT_IMPL(a_div_count_nonzero, clk, rst_n, div_req.start, div_req.count != '0)

endmodule

// ===== hdl/bmf_mean_div.sv =====
// Two-stage divider of a neighbourhood sum by its count (1, 2, 3, 4, 6 or 9), truncating toward zero.
// Reciprocal multiply, then one correction step. Depends on bmf_pkg.
module bmf_mean_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bmf_pkg::div_req_t req,
  output bmf_pkg::div_rsp_t rsp
);

  localparam int PROD_W = bmf_pkg::ABS_W + bmf_pkg::DIV_SHIFT;

  logic signed [bmf_pkg::SUM_W-1:0] sum_neg;
  logic [bmf_pkg::ABS_W-1:0]        abs_in;
  logic [PROD_W-1:0]                prod_nxt;

  logic [bmf_pkg::ABS_W-1:0] abs_r;
  logic                      neg_r;
  logic [bmf_pkg::CNT_W-1:0] d_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      v1_r;
  logic                      done_r;
  bmf_pkg::sample_t          q_r;

  logic [bmf_pkg::ABS_W-1:0] q0;
  logic [bmf_pkg::ABS_W-1:0] qd;
  logic [bmf_pkg::ABS_W-1:0] rem;
  logic [bmf_pkg::ABS_W-1:0] qfix;
  logic [bmf_pkg::ABS_W-1:0] qfix_neg;
  bmf_pkg::sample_t          q_nxt;

  assign sum_neg  = -req.sum;
  assign abs_in   = bmf_pkg::ABS_W'(req.sum[bmf_pkg::SUM_W-1] ? sum_neg : req.sum);
  assign prod_nxt = PROD_W'(abs_in) * PROD_W'(bmf_pkg::recip(req.count));

  always_ff @(posedge clk) begin
    if (req.start) begin
      abs_r  <= abs_in;
      neg_r  <= req.sum[bmf_pkg::SUM_W-1];
      d_r    <= req.count;
      prod_r <= prod_nxt;
    end
  end

  // The floored reciprocal leaves the estimate at most one below the true quotient.
  assign q0       = prod_r[PROD_W-1:bmf_pkg::DIV_SHIFT];
  assign qd       = bmf_pkg::ABS_W'(q0 * bmf_pkg::ABS_W'(d_r));
  assign rem      = abs_r - qd;
  assign qfix     = (rem >= bmf_pkg::ABS_W'(d_r)) ? q0 + 1'b1 : q0;
  assign qfix_neg = -qfix;
  assign q_nxt    = bmf_pkg::SAMPLE_BITS'(neg_r ? qfix_neg : qfix);

  always_ff @(posedge clk) begin
    if (v1_r) begin
      q_r <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= req.start;
      done_r <= v1_r;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule
